[hw/rtl/sgmd_pkg.sv]
// Shared constants, types and helper functions for the Sobel gradient block.
package sgmd_pkg;
  localparam int MaxWidth = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);
  localparam int SizeW = 11;
  localparam int SqW = 21;          // gx^2+gy^2 fits 21 bits
  localparam int RootW = 15;        // sqrt of (sq << 8)
  localparam int RadW = 30;         // radicand width, even
  localparam int Cells = RootW;     // one root bit per cell

  localparam logic [SizeW-1:0] WidthReset = 11'd640;
  localparam logic [SizeW-1:0] HeightReset = 11'd480;

  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;

  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [1:0]         dir;
    logic               fe;
  } side_t;

  // The partial root sits high in the radicand's range until the last
  // cells shift it down, so it needs the full radicand width.
  typedef struct packed {
    logic [RadW-1:0]  rem;
    logic [RadW-1:0]  root;
    side_t            side;
    logic             valid;
  } cell_t;

  typedef struct packed {
    logic [7:0] l0, l1, l2, c0, c2, r0, r1, r2;
    logic       fe;
  } win_t;

  function automatic logic [1:0] sector(input logic signed [10:0] gx,
                                        input logic signed [10:0] gy);
    logic signed [11:0] u;
    logic [10:0] a, b;
    logic [23:0] s1, s2, aa2;
    logic [11:0] apb, bma;
    logic [1:0] res;
    u = (gx < 0) ? -12'(gy) : 12'(gy);
    a = (u < 0) ? 11'(-u) : 11'(u);
    b = (gx < 0) ? 11'(-gx) : 11'(gx);
    apb = 12'(a) + 12'(b);
    bma = 12'(b) - 12'(a);
    s1 = 24'(apb) * 24'(apb);
    s2 = 24'(bma) * 24'(bma);
    aa2 = 24'(a) * 24'(a) * 24'd2;
    if (gx == 0) res = 2'd0;
    else if (s1 < aa2) res = 2'd0;
    else if (b <= a || s2 < aa2) res = (u > 0) ? 2'd1 : 2'd3;
    else res = 2'd2;
    return res;
  endfunction
endpackage

[hw/rtl/sgmd_sqrt_cell.sv]
// One stage of the restoring square root chain: settles one root bit.
module sgmd_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           stall,
  input  sgmd_pkg::cell_t prev,
  input  logic [4:0]     stage,
  output sgmd_pkg::cell_t cur
);
  import sgmd_pkg::*;
  logic [RadW-1:0] bitv, trial;
  cell_t nxt;
  always_comb begin
    bitv = RadW'(1) << (RadW - 2 - 2 * 32'(stage));
    trial = prev.root + bitv;
    nxt = prev;
    if (prev.rem >= trial) begin
      nxt.rem = prev.rem - trial;
      nxt.root = (prev.root >> 1) + bitv;
    end else begin
      nxt.root = prev.root >> 1;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) cur.valid <= 1'b0;
    else if (!stall) cur.valid <= prev.valid;
    if (!stall) begin
      cur.rem <= nxt.rem;
      cur.root <= nxt.root;
      cur.side <= nxt.side;
    end
  end
endmodule

[hw/rtl/sgmd_window.sv]
// Line stores, 3x3 window and frame counters; issues window taps per result.
module sgmd_window (
  input  logic              clk,
  input  logic              rst,
  input  logic [10:0]       frame_width,
  input  logic [10:0]       frame_height,
  input  logic              in_valid,
  input  logic              action,
  input  logic [7:0]        pixel,
  input  logic              stall,
  output logic              busy,
  output logic              tap_valid,
  output sgmd_pkg::win_t    tap
);
  import sgmd_pkg::*;
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_RD = 4'b0010, ST_PIX = 4'b0100, ST_DR = 4'b1000
  } state_t;
  state_t state;
  logic [7:0] upper [MaxWidth];
  logic [7:0] lower [MaxWidth];
  logic [7:0] w0 [3], w1 [3], w2 [3];
  logic [7:0] rd_u0, rd_l0, rd_u1, rd_l1;
  logic [ColW:0] col, dcol;
  logic [RowW:0] row;
  logic pend, single, is_drain, second;
  logic [7:0] pix;
  logic [ColW:0] w, h, c, ra, rb;
  logic [ColW-1:0] a0, a1;
  logic last_col;
  // Column of the pixel being emitted, latched when the pixel is taken.
  logic [ColW:0] pc;
  logic plast, ra_c1;
  logic emit;

  always_comb begin
    w = (frame_width == 0) ? (ColW+1)'(1) :
        (frame_width > MaxWidth) ? (ColW+1)'(MaxWidth) : frame_width[ColW:0];
    h = (frame_height == 0) ? (ColW+1)'(1) :
        (frame_height > MaxHeight) ? (ColW+1)'(MaxHeight) : frame_height[ColW:0];
    c = (col < w) ? col : w - 1'b1;
    last_col = (c == w - 1'b1);
    ra = dcol;
    if (!(action)) begin
      ra = c; rb = c;
    end else begin
      ra = (dcol > 0) ? dcol - 1'b1 : dcol;
      rb = (dcol + 1'b1 < w) ? dcol + 1'b1 : dcol;
    end
    a0 = ra[ColW-1:0];
    a1 = rb[ColW-1:0];
  end

  assign busy = (state != ST_IDLE);
  assign emit = ((state == ST_PIX) && ((!second && ra_c1) || plast)) || (state == ST_DR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; col <= '0; row <= '0; dcol <= '0; pend <= 1'b0;
      single <= 1'b0; tap_valid <= 1'b0; second <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        w0[i] <= '0; w1[i] <= '0; w2[i] <= '0;
      end
    end else begin
      if (!stall) tap_valid <= emit;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            pix <= pixel; is_drain <= action;
            rd_u0 <= upper[a0]; rd_l0 <= lower[a0];
            rd_u1 <= upper[a1]; rd_l1 <= lower[a1];
            state <= ST_RD;
          end
        end
        ST_RD: begin
          if (is_drain) begin
            if (pend && dcol < w) state <= ST_DR;
            else state <= ST_IDLE;
            if (pend && dcol >= w) pend <= 1'b0;
          end else begin
            upper[c[ColW-1:0]] <= rd_l0;
            lower[c[ColW-1:0]] <= pix;
            pend <= last_col && (row + 1'b1 >= h);
            if (row >= 1) begin
              w0 <= w1; w1 <= w2;
              w2[0] <= (row == 1) ? rd_l0 : rd_u0;
              w2[1] <= rd_l0; w2[2] <= pix;
              state <= ST_PIX; second <= 1'b0;
            end else state <= ST_IDLE;
            if (last_col) begin
              col <= '0;
              if (row + 1'b1 >= h) begin
                row <= '0; dcol <= '0; single <= (row == 0);
              end else row <= row + 1'b1;
            end else col <= c + 1'b1;
          end
        end
        ST_PIX: begin
          // col has already moved on, so this pixel's column comes from pc
          // and plast; the first result is for the column before it.
          if (!stall) begin
            if (!second && ra_c1) begin
              tap <= '{l0: (pc == 1) ? w1[0] : w0[0], l1: (pc == 1) ? w1[1] : w0[1],
                       l2: (pc == 1) ? w1[2] : w0[2], c0: w1[0], c2: w1[2],
                       r0: w2[0], r1: w2[1], r2: w2[2], fe: 1'b0};
              second <= 1'b1;
              if (!plast) state <= ST_IDLE;
            end else if (plast) begin
              tap <= '{l0: (w == 1) ? w2[0] : w1[0], l1: (w == 1) ? w2[1] : w1[1],
                       l2: (w == 1) ? w2[2] : w1[2], c0: w2[0], c2: w2[2],
                       r0: w2[0], r1: w2[1], r2: w2[2], fe: 1'b0};
              state <= ST_IDLE;
            end else state <= ST_IDLE;
          end
        end
        ST_DR: begin
          if (!stall) begin
            tap <= '{l0: single ? rd_l0 : rd_u0, l1: rd_l0, l2: rd_l0,
                     c0: single ? lower[dcol[ColW-1:0]] : upper[dcol[ColW-1:0]],
                     c2: lower[dcol[ColW-1:0]],
                     r0: single ? rd_l1 : rd_u1, r1: rd_l1, r2: rd_l1,
                     fe: (dcol == w - 1'b1)};
            dcol <= dcol + 1'b1;
            if (dcol == w - 1'b1) pend <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      pc <= c; plast <= last_col;
    end
  end
  assign ra_c1 = (pc >= 1);
endmodule

[hw/rtl/sobel_gradient_magnitude_direction.sv]
// Top level: configuration registers, window, Sobel sums and root chain.
// Items are taken one at a time. A pixel of the first row, or a drain with
// nothing pending, frees the input after a memory read and a window
// update. A pixel or drain with one result passes read, update, emission,
// and the tap's entry into the root chain before the input is free. A pixel
// that ends a row gives two results. Whenever the output beat waits for
// m_tready the whole chain holds, and the input waits with it. Results pass
// a 15-cell square root chain, one root bit per cell, and the output
// register; a second result follows its item's first one.
module sobel_gradient_magnitude_direction (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // pixel
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // grad_x, grad_y, magnitude, direction, zero pad
  output logic        m_tlast    // frame_end
);
  import sgmd_pkg::*;
  logic [10:0] fw, fh;
  logic busy, tap_valid, stall;
  win_t tap;
  cell_t chain [Cells+1];

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= WidthReset; fh <= HeightReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegHeight[0]) fh <= pwdata[10:0];
      else fw <= pwdata[10:0];
    end
  end
  assign prdata = paddr[2] ? {21'd0, fh} : {21'd0, fw};

  // Output register: the chain freezes whenever the result is not taken.
  assign stall = m_tvalid && !m_tready;
  assign s_tready = !busy && !stall && !tap_valid;

  sgmd_window u_win (
    .clk, .rst, .frame_width(fw), .frame_height(fh),
    .in_valid(s_tvalid && s_tready), .action(s_tuser), .pixel(s_tdata),
    .stall, .busy, .tap_valid, .tap
  );

  logic signed [10:0] gx, gy;
  logic [SqW-1:0] sq;
  always_comb begin
    gx = (11'(tap.r0) + 11'(tap.r1) * 11'sd2 + 11'(tap.r2))
       - (11'(tap.l0) + 11'(tap.l1) * 11'sd2 + 11'(tap.l2));
    gy = (11'(tap.l0) + 11'(tap.c0) * 11'sd2 + 11'(tap.r0))
       - (11'(tap.l2) + 11'(tap.c2) * 11'sd2 + 11'(tap.r2));
    sq = SqW'(22'(gx * gx) + 22'(gy * gy));
    chain[0].valid = tap_valid && !stall;
    chain[0].rem = RadW'({sq, 8'd0});
    chain[0].root = '0;
    chain[0].side = '{gx: gx, gy: gy, dir: sector(gx, gy), fe: tap.fe};
  end

  // Every cell holds while the output beat waits, so nothing in flight
  // can overrun the output register.
  for (genvar i = 0; i < Cells; i++) begin : g_cell
    sgmd_sqrt_cell u_cell (.clk, .rst, .stall, .prev(chain[i]), .stage(5'(i)),
                           .cur(chain[i+1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!stall) begin
      m_tvalid <= chain[Cells].valid;
      if (chain[Cells].valid) begin
        m_tdata <= {1'b0, chain[Cells].side.dir, chain[Cells].root[RootW-1:0],
                    chain[Cells].side.gy, chain[Cells].side.gx};
        m_tlast <= chain[Cells].side.fe;
      end
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed while waiting");
  a_one_tap: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !tap_valid) else $error("accept with tap pending");
endmodule
